[hw/rtl/julian_day_calendar_converter_macros.svh]
// ----------------------------------------------------------------------------
// Julian day converter assertion macros
// Concurrent assertion wrappers used by the top-level converter module.
// ----------------------------------------------------------------------------
`ifndef JULIAN_DAY_CALENDAR_CONVERTER_MACROS_SVH
`define JULIAN_DAY_CALENDAR_CONVERTER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Overlapping implication: cons is checked in the same cycle as ante.
`define JDC_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jdc assertion failed");
// Non-overlapping implication: cons is checked in the cycle after ante.
`define JDC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jdc assertion failed");
`else
`define JDC_ASSERT_SAME(name, clk, rst_n, ante, cons)
`define JDC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/jdc_pkg.sv]
// ----------------------------------------------------------------------------
// Julian day converter package
// Types, constants and the month offset table shared by the converter.
// ----------------------------------------------------------------------------
package jdc_pkg;

    typedef logic signed [14:0] t_year;
    typedef logic        [3:0]  t_month;
    typedef logic        [4:0]  t_day;
    typedef logic        [22:0] t_jdn;

    typedef enum logic {
        CMD_TO_JDN  = 1'b0,
        CMD_TO_DATE = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic err;
    } t_ctl;

    // Registers inside each datapath module between the input and output registers.
    localparam int PIPE_DEPTH = 4;
    // Edges from acceptance to the edge that takes the result beat.
    localparam int RESULT_LAT = PIPE_DEPTH + 2;

    localparam t_year  YEAR_MIN  = -15'sd4713;
    localparam t_year  YEAR_MAX  = 15'sd9999;
    localparam t_month MONTH_MIN = 4'd1;
    localparam t_month MONTH_MAX = 4'd12;
    localparam t_day   DAY_MIN   = 5'd1;
    localparam t_day   DAY_MAX   = 5'd31;
    localparam t_jdn   JDN_MAX   = 23'd5373484;

    // Calendar switch, 1582-10-15.
    localparam t_year  SWITCH_YEAR  = 15'sd1582;
    localparam t_month SWITCH_MONTH = 4'd10;
    localparam t_day   SWITCH_DAY   = 5'd15;
    localparam t_jdn   GREG_JDN     = 23'd2299161;

    localparam t_jdn  JDN_EPOCH   = 23'd1720995;
    localparam t_jdn  ALPHA_BASE  = 23'd1867216;
    localparam t_jdn  DAY_OFFSET  = 23'd1524;
    localparam t_year YEAR_BASE   = 15'sd4715;
    localparam logic [11:0] DAYS_4Y = 12'd1461;
    // 100*b - 12210 over 36525 is reduced by 5 to 20*b - 2442 over 7305.
    localparam logic [26:0] C_BIAS = 27'd2442;

    // Reciprocals: floor(x*R / 2^S) equals floor(x / divisor) over the used x range.
    localparam logic [22:0] ALPHA_RECIP = 23'd7525902;   // divisor 146097, x < 2^24
    localparam int          ALPHA_SHIFT = 40;
    localparam logic [27:0] C_RECIP     = 28'd150514939; // divisor 7305, x < 2^27
    localparam int          C_SHIFT     = 40;
    localparam logic [11:0] CENT_RECIP  = 12'd2622;      // divisor 25, x < 2500
    localparam int          CENT_SHIFT  = 16;

    localparam int E_MAX = 16;

    // floor(30.6001 * e) for the month codes of the scheme.
    function automatic logic [8:0] f30(input logic [4:0] e);
        logic [8:0] v;
        unique case (e)
            5'd1:    v = 9'd30;
            5'd2:    v = 9'd61;
            5'd3:    v = 9'd91;
            5'd4:    v = 9'd122;
            5'd5:    v = 9'd153;
            5'd6:    v = 9'd183;
            5'd7:    v = 9'd214;
            5'd8:    v = 9'd244;
            5'd9:    v = 9'd275;
            5'd10:   v = 9'd306;
            5'd11:   v = 9'd336;
            5'd12:   v = 9'd367;
            5'd13:   v = 9'd397;
            5'd14:   v = 9'd428;
            5'd15:   v = 9'd459;
            5'd16:   v = 9'd489;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/jdc_date2jdn.sv]
// ----------------------------------------------------------------------------
// Date to day number datapath
// Two working stages, then delay registers to match the reverse path.
// ----------------------------------------------------------------------------
module jdc_date2jdn import jdc_pkg::*; (
    input  logic   i_clk,
    input  t_year  i_year,
    input  t_month i_month,
    input  t_day   i_day,
    output t_jdn   o_day_number
);

    logic signed [14:0] n_y1;
    logic signed [14:0] n_iy;
    logic signed [14:0] n_jy;
    logic               n_late;
    logic        [4:0]  n_jm;
    logic               n_greg;
    logic signed [26:0] n_py;
    logic        [23:0] n_pc;

    logic signed [26:0] r_py;
    logic        [23:0] r_pc;
    logic               r_greg;
    logic        [8:0]  r_f30;
    t_day               r_day;

    logic        [6:0]  n_cent;
    logic        [24:0] n_adj;
    logic        [24:0] n_sum;

    t_jdn r_jdn [PIPE_DEPTH-1];

    // Stage 1: shift the year so that January and February close the
    // previous year, then form 1461*jy and the century reciprocal product.
    always_comb begin
        n_y1   = (i_year == '0) ? 15'sd1 : i_year;
        n_iy   = n_y1[14] ? (n_y1 + 15'sd1) : n_y1;
        n_late = (i_month > 4'd2);
        n_jy   = n_late ? n_iy : (n_iy - 15'sd1);
        n_jm   = n_late ? (5'(i_month) + 5'd1) : (5'(i_month) + 5'd13);
        n_greg = (n_iy > SWITCH_YEAR) ||
                 ((n_iy == SWITCH_YEAR) &&
                  ((i_month > SWITCH_MONTH) ||
                   ((i_month == SWITCH_MONTH) && (i_day >= SWITCH_DAY))));
        n_py   = 27'(n_jy) * $signed({15'd0, DAYS_4Y});
        n_pc   = 24'(n_jy[13:2]) * 24'(CENT_RECIP);
    end

    always_ff @(posedge i_clk) begin
        r_py   <= n_py;
        r_pc   <= n_pc;
        r_greg <= n_greg;
        r_f30  <= f30(n_jm);
        r_day  <= i_day;
    end

    // Stage 2: sum the terms; the Gregorian correction is 2 - cent + cent/4.
    always_comb begin
        n_cent = r_pc[CENT_SHIFT+6:CENT_SHIFT];
        n_adj  = r_greg ? (25'd2 + 25'(n_cent[6:2]) - 25'(n_cent)) : 25'd0;
        n_sum  = 25'(r_day) + 25'(r_f30) + 25'(r_py >>> 2) + 25'(JDN_EPOCH) + n_adj;
    end

    always_ff @(posedge i_clk) begin
        r_jdn[0] <= n_sum[22:0];
        for (int i = 1; i < PIPE_DEPTH - 1; i++) begin
            r_jdn[i] <= r_jdn[i-1];
        end
    end

    assign o_day_number = r_jdn[PIPE_DEPTH-2];

endmodule

[hw/rtl/jdc_jdn2date.sv]
// ----------------------------------------------------------------------------
// Day number to date datapath
// Four registered stages; the month search and year fix-up follow the last.
// ----------------------------------------------------------------------------
module jdc_jdn2date import jdc_pkg::*; (
    input  logic   i_clk,
    input  t_jdn   i_day_number,
    output t_year  o_year,
    output t_month o_month,
    output t_day   o_day
);

    logic [22:0] n_t;
    logic [23:0] n_xa;
    logic [46:0] n_pa;
    logic [6:0]  r1_alpha;
    t_jdn        r1_jdn;
    logic        r1_greg;

    logic [7:0]  n_corr;
    logic [22:0] n_a;
    logic [22:0] n_b;
    logic [26:0] n_x;
    logic [22:0] r2_b;
    logic [26:0] r2_x;

    logic [54:0] n_pc;
    logic [13:0] r3_c;
    logic [22:0] r3_b;

    logic [22:0] n_d;
    logic [22:0] n_g;
    logic [8:0]  r4_g;
    logic [13:0] r4_c;

    logic [4:0]         n_e;
    logic [4:0]         n_m;
    logic [8:0]         n_dd;
    logic signed [14:0] n_y;

    // Stage 1: alpha = floor((4*(jdn - 1867216) - 1) / 146097).
    always_comb begin
        n_t  = i_day_number - ALPHA_BASE;
        n_xa = {n_t[21:0], 2'b00} - 24'd1;
        n_pa = 47'(n_xa) * 47'(ALPHA_RECIP);
    end

    always_ff @(posedge i_clk) begin
        r1_alpha <= n_pa[ALPHA_SHIFT+6:ALPHA_SHIFT];
        r1_jdn   <= i_day_number;
        r1_greg  <= (i_day_number >= GREG_JDN);
    end

    // Stage 2: a, b and the scaled numerator for the year count c.
    always_comb begin
        n_corr = 8'd1 + {1'b0, r1_alpha} - {3'd0, r1_alpha[6:2]};
        n_a    = r1_jdn + (r1_greg ? 23'(n_corr) : 23'd0);
        n_b    = n_a + DAY_OFFSET;
        n_x    = {n_b, 4'b0000} + {2'b00, n_b, 2'b00} - C_BIAS;
    end

    always_ff @(posedge i_clk) begin
        r2_b <= n_b;
        r2_x <= n_x;
    end

    // Stage 3: c = floor(x / 7305).
    assign n_pc = 55'(r2_x) * 55'(C_RECIP);

    always_ff @(posedge i_clk) begin
        r3_c <= n_pc[C_SHIFT+13:C_SHIFT];
        r3_b <= r2_b;
    end

    // Stage 4: days counted from the start of the shifted year.
    always_comb begin
        n_d = 23'(r3_c) * 23'd365 + 23'(r3_c[13:2]);
        n_g = r3_b - n_d;
    end

    always_ff @(posedge i_clk) begin
        r4_g <= n_g[8:0];
        r4_c <= r3_c;
    end

    // Month code e is the largest e with floor(30.6001*e) below g; since
    // 30.6001*e is never whole here, that is also floor(g / 30.6001).
    always_comb begin
        n_e = '0;
        for (int k = 1; k <= E_MAX; k++) begin
            if (r4_g > f30(5'(k))) begin
                n_e = 5'(k);
            end
        end
        n_dd = r4_g - f30(n_e);
        n_m  = n_e - 5'd1;
        if (n_m > 5'd12) begin
            n_m = n_m - 5'd12;
        end
        n_y = $signed({1'b0, r4_c}) - YEAR_BASE;
        if (n_m > 5'd2) begin
            n_y = n_y - 15'sd1;
        end
        if (n_y <= 15'sd0) begin
            n_y = n_y - 15'sd1;
        end
    end

    assign o_year  = n_y;
    assign o_month = n_m[3:0];
    assign o_day   = n_dd[4:0];

endmodule

[hw/rtl/julian_day_calendar_converter.sv]
// ----------------------------------------------------------------------------
// Julian day calendar converter
// Converts a calendar date to a Julian day number or a day number to a date.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Beat contents
//  -------   -------------------   ---------------------------------------------
//  command   start / busy          i_command, i_year, i_month, i_day, i_day_number
//  result    o_strobe (one cycle)  o_day_number, o_year, o_month, o_day,
//                                  o_range_error
//
// A command beat is taken at every rising edge where start is high and busy
// is low; busy is held low, so one beat can be taken in every cycle.
// Each result beat passes through an input register, the four pipeline
// registers of the day-number-to-date path (the alpha and year-count
// reciprocal multipliers set this depth), and the result register. The
// date-to-day-number path is padded to the same depth.
// The synchronous reset clears the valid chain and drops any beat in flight.
// The result side cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`include "julian_day_calendar_converter_macros.svh"

module julian_day_calendar_converter import jdc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    output logic   busy,
    input  logic   i_command,
    input  t_year  i_year,
    input  t_month i_month,
    input  t_day   i_day,
    input  t_jdn   i_day_number,
    output logic   o_strobe,
    output t_jdn   o_day_number,
    output t_year  o_year,
    output t_month o_month,
    output t_day   o_day,
    output logic   o_range_error
);

    logic accept;
    logic n_err;

    // Input register. The payload loads every cycle; only the valid chain
    // says which slots carry a real beat.
    t_year  r_year;
    t_month r_month;
    t_day   r_day;
    t_jdn   r_jdn;

    logic r_vld [PIPE_DEPTH+1];
    t_ctl r_ctl [PIPE_DEPTH+1];

    t_jdn   w_day_number;
    t_year  w_year;
    t_month w_month;
    t_day   w_day;

    t_jdn   n_out_jdn;
    t_year  n_out_year;
    t_month n_out_month;
    t_day   n_out_day;

    logic   r_strobe;
    t_jdn   r_out_jdn;
    t_year  r_out_year;
    t_month r_out_month;
    t_day   r_out_day;
    logic   r_out_err;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // The range check looks only at the fields that the command uses.
    always_comb begin
        if (t_cmd'(i_command) == CMD_TO_DATE) begin
            n_err = (i_day_number > JDN_MAX);
        end else begin
            n_err = (i_year < YEAR_MIN) || (i_year > YEAR_MAX) ||
                    (i_month < MONTH_MIN) || (i_month > MONTH_MAX) ||
                    (i_day < DAY_MIN) || (i_day > DAY_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        r_year   <= i_year;
        r_month  <= i_month;
        r_day    <= i_day;
        r_jdn    <= i_day_number;
        r_ctl[0] <= '{cmd: t_cmd'(i_command), err: n_err};
        for (int i = 1; i <= PIPE_DEPTH; i++) begin
            r_ctl[i] <= r_ctl[i-1];
        end
    end

    // Valid chain, one bit per pipeline slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= PIPE_DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= accept;
            for (int i = 1; i <= PIPE_DEPTH; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // Both paths run on every beat; the command picks which one is shown.
    jdc_date2jdn u_date2jdn (
        .i_clk        (i_clk),
        .i_year       (r_year),
        .i_month      (r_month),
        .i_day        (r_day),
        .o_day_number (w_day_number)
    );

    jdc_jdn2date u_jdn2date (
        .i_clk        (i_clk),
        .i_day_number (r_jdn),
        .o_year       (w_year),
        .o_month      (w_month),
        .o_day        (w_day)
    );

    // Result register. An out-of-range beat reports only the error flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld[PIPE_DEPTH];
        end
    end

    always_comb begin
        n_out_jdn   = '0;
        n_out_year  = '0;
        n_out_month = '0;
        n_out_day   = '0;
        if (!r_ctl[PIPE_DEPTH].err) begin
            unique case (r_ctl[PIPE_DEPTH].cmd)
                CMD_TO_JDN: begin
                    n_out_jdn = w_day_number;
                end
                CMD_TO_DATE: begin
                    n_out_year  = w_year;
                    n_out_month = w_month;
                    n_out_day   = w_day;
                end
                default: begin
                    n_out_jdn = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_jdn   <= n_out_jdn;
        r_out_year  <= n_out_year;
        r_out_month <= n_out_month;
        r_out_day   <= n_out_day;
        r_out_err   <= r_ctl[PIPE_DEPTH].err;
    end

    assign o_strobe      = r_strobe;
    assign o_day_number  = r_out_jdn;
    assign o_year        = r_out_year;
    assign o_month       = r_out_month;
    assign o_day         = r_out_day;
    assign o_range_error = r_out_err;

    // Every taken command yields its result beat after the fixed latency.
    `JDC_ASSERT_SAME(a_fixed_latency, i_clk, i_rst_n, accept, ##(RESULT_LAT) o_strobe)
    // No result beat without a beat at the end of the pipeline.
    `JDC_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !r_vld[PIPE_DEPTH], !o_strobe)
    // An error beat carries nothing but the flag.
    `JDC_ASSERT_SAME(a_err_zero, i_clk, i_rst_n, o_strobe && o_range_error,
        (o_day_number == '0) && (o_year == '0) && (o_month == '0) && (o_day == '0))
    // A decoded date never shows year zero and never mixes with a day number.
    `JDC_ASSERT_SAME(a_date_shape, i_clk, i_rst_n, o_strobe && (o_month != '0),
        (o_year != '0) && (o_day != '0) && (o_day_number == '0) && !o_range_error)

endmodule
